FILE: hdl/hmtq_pkg.sv
// Package with shared types and constants of the heightmap height query unit.
`timescale 1ns / 1ps
`default_nettype none
package hmtq_pkg;

	// Grid geometry and sample width.
	localparam int GRID_SIDE   = 128;
	localparam int HEIGHT_BITS = 8;
	localparam int ADDR_W      = $clog2(GRID_SIDE * GRID_SIDE);
	localparam int DIM_W       = $clog2(GRID_SIDE) + 1;
	localparam int IDX_W       = $clog2(GRID_SIDE);

	// Depths of the command queue and of the result buffer.
	localparam int QUEUE_DEPTH = 4;
	localparam int OUT_DEPTH   = 4;

	// Request types.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_GRID_ROWS     = 3'd0;
	localparam logic [2:0] REG_ROW_LENGTH    = 3'd1;
	localparam logic [2:0] REG_SPACING_RECIP = 3'd2;
	localparam logic [2:0] REG_HEIGHT_SCALE  = 3'd3;
	localparam logic [2:0] REG_HEIGHT_OFFSET = 3'd4;

	// Corner fetch phases.
	localparam logic [1:0] PH_BL  = 2'd0;
	localparam logic [1:0] PH_TR  = 2'd1;
	localparam logic [1:0] PH_TRI = 2'd2;

	// Current configuration, with dimensions already clamped.
	typedef struct packed {
		logic [DIM_W-1:0] grid_rows;
		logic [DIM_W-1:0] row_length;
		logic [31:0]      spacing_recip;
		logic [23:0]      height_scale;
		logic [31:0]      height_offset;
	} cfg_t;

	// Classified command passed from the front to the back.
	typedef struct packed {
		logic                   is_wr;
		logic [ADDR_W-1:0]      addr;
		logic [HEIGHT_BITS-1:0] value;
		logic                   in_range;
		logic [IDX_W-1:0]       col;
		logic [IDX_W-1:0]       row;
		logic [15:0]            fx;
		logic [15:0]            fz;
		logic                   upper;
	} cmd_t;

	// One finished result.
	typedef struct packed {
		logic [31:0] height;
		logic        in_range;
	} res_t;

endpackage
`default_nettype wire

FILE: hdl/hmtq_if.sv
// Request and result channel interfaces of the heightmap height query unit.
`timescale 1ns / 1ps
`default_nettype none
interface hmtq_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [6:0]  first_index;
	logic [6:0]  second_index;
	logic [7:0]  entry_value;
	logic [31:0] query_x;
	logic [31:0] query_z;

	modport source (output valid, req_type, first_index, second_index, entry_value,
		query_x, query_z, input ready);
	modport sink (input valid, req_type, first_index, second_index, entry_value,
		query_x, query_z, output ready);
endinterface

interface hmtq_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] height;
	logic        in_range;

	modport source (output valid, height, in_range, input ready);
	modport sink (input valid, height, in_range, output ready);
endinterface
`default_nettype wire

FILE: hdl/hmtq_queue.sv
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module hmtq_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hmtq_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output hmtq_pkg::cmd_t     head,
	output logic               head_valid
);
	localparam int PW = $clog2(hmtq_pkg::QUEUE_DEPTH);

	hmtq_pkg::cmd_t  entry_q [hmtq_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;

	assign full       = (cnt_q == (PW+1)'(hmtq_pkg::QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = entry_q[rp_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) entry_q[wp_q] <= push_data;
	end
endmodule
`default_nettype wire

FILE: hdl/hmtq_front.sv
// Front end: accepts requests, scales query coordinates and classifies them.
`timescale 1ns / 1ps
`default_nettype none
module hmtq_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hmtq_pkg::cfg_t cfg,
	hmtq_in_if.sink             req,
	output logic                push,
	output hmtq_pkg::cmd_t      push_data,
	input  wire logic           q_full
);
	// Stage 1 registers.
	logic                           v_s1;
	logic                           wr_s1;
	logic [hmtq_pkg::ADDR_W-1:0]    addr_s1;
	logic [hmtq_pkg::HEIGHT_BITS-1:0] value_s1;
	logic signed [64:0]             px_s1;
	logic signed [64:0]             pz_s1;
	// Stage 2 registers.
	logic                           v_s2;
	hmtq_pkg::cmd_t                 cmd_s2;

	logic                           adv2;
	logic [14:0]                    waddr;
	logic [hmtq_pkg::DIM_W-1:0]     rlm1;
	logic [hmtq_pkg::DIM_W-1:0]     grm1;
	logic signed [49:0]             sx;
	logic signed [49:0]             sz;
	logic signed [49:0]             cx;
	logic signed [49:0]             cz;
	logic signed [49:0]             lim_x;
	logic signed [49:0]             lim_z;
	logic [16:0]                    fsum;
	hmtq_pkg::cmd_t                 cmd_c;

	assign adv2      = !v_s2 || !q_full;
	assign req.ready = !v_s1 || adv2;
	assign push      = v_s2 && !q_full;
	assign push_data = cmd_s2;

	// Store address for writes; always inside the store for legal dimensions.
	assign waddr = 15'(req.first_index) * 15'(cfg.row_length) + 15'(req.second_index);

	// Stage 1: accept and multiply both coordinates by the reciprocal spacing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (req.ready) v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			wr_s1    <= (req.req_type == hmtq_pkg::REQ_WRITE);
			addr_s1  <= waddr[hmtq_pkg::ADDR_W-1:0];
			value_s1 <= req.entry_value;
			px_s1    <= $signed(req.query_x) * $signed({1'b0, cfg.spacing_recip});
			pz_s1    <= $signed(req.query_z) * $signed({1'b0, cfg.spacing_recip});
		end
	end

	// Stage 2 logic: grid cell coordinates, bounds check and triangle choice.
	always_comb begin
		rlm1  = cfg.row_length - 1'b1;
		grm1  = cfg.grid_rows - 1'b1;
		sx    = 50'(px_s1 >>> 16);
		sz    = 50'(pz_s1 >>> 16);
		cx    = sx + $signed({27'b0, rlm1, 15'b0});
		cz    = $signed({27'b0, grm1, 15'b0}) - sz;
		lim_x = $signed({26'b0, rlm1, 16'b0});
		lim_z = $signed({26'b0, grm1, 16'b0});
		fsum  = {1'b0, cx[15:0]} + {1'b0, cz[15:0]};

		cmd_c          = '0;
		cmd_c.is_wr    = wr_s1;
		cmd_c.addr     = addr_s1;
		cmd_c.value    = value_s1;
		cmd_c.in_range = !cx[49] && !cz[49] && (cx <= lim_x) && (cz <= lim_z);
		cmd_c.col      = cx[16 +: hmtq_pkg::IDX_W];
		cmd_c.row      = cz[16 +: hmtq_pkg::IDX_W];
		cmd_c.fx       = cx[15:0];
		cmd_c.fz       = cz[15:0];
		cmd_c.upper    = !fsum[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv2) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) cmd_s2 <= cmd_c;
	end
endmodule
`default_nettype wire

FILE: hdl/hmtq_back.sv
// Back end: height store, corner fetch sequencer, interpolation and result buffer.
`timescale 1ns / 1ps
`default_nettype none
module hmtq_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hmtq_pkg::cfg_t cfg,
	input  wire hmtq_pkg::cmd_t head,
	input  wire logic           head_valid,
	output logic                pop,
	hmtq_out_if.source          rsp
);
	localparam int HB = hmtq_pkg::HEIGHT_BITS;
	localparam int OW = $clog2(hmtq_pkg::OUT_DEPTH);

	// Height store.
	logic [HB-1:0]               mem [hmtq_pkg::GRID_SIDE * hmtq_pkg::GRID_SIDE];
	logic [HB-1:0]               rd_q;

	// Fetch sequencer.
	logic                        busy_q;
	logic [1:0]                  phase_q;
	hmtq_pkg::cmd_t              cur_q;
	logic [OW:0]                 inflight_q;

	// Read stage.
	logic                        rvld_s1;
	logic [1:0]                  rph_s1;
	logic                        rz_s1;
	logic                        fin_s1;
	hmtq_pkg::cmd_t              meta_s1;
	logic [HB-1:0]               bl_q;
	logic [HB-1:0]               tr_q;

	// Arithmetic stages.
	logic                        v_s2;
	logic                        ir_s2;
	logic [HB-1:0]               base_s2;
	logic signed [HB+18:0]       p1_s2;
	logic signed [HB+18:0]       p2_s2;
	logic                        v_s3;
	logic                        ir_s3;
	logic signed [HB+20:0]       h_s3;
	logic                        v_s4;
	logic                        ir_s4;
	logic signed [HB+44:0]       m_s4;

	// Result buffer.
	hmtq_pkg::res_t              ob_q [hmtq_pkg::OUT_DEPTH];
	logic [OW-1:0]               owp_q;
	logic [OW-1:0]               orp_q;
	logic [OW:0]                 ocnt_q;

	logic                        is_query;
	logic                        wr_en;
	logic                        oor_pop;
	logic                        iss;
	logic                        iss_last;
	logic [1:0]                  phase;
	hmtq_pkg::cmd_t              src;
	logic [hmtq_pkg::DIM_W-1:0]  ca;
	logic [hmtq_pkg::DIM_W-1:0]  cb;
	logic                        czero;
	logic [2*hmtq_pkg::DIM_W-1:0] raddr;
	logic [hmtq_pkg::ADDR_W-1:0] maddr;
	logic [HB-1:0]               sample;
	logic signed [HB:0]          d1;
	logic signed [HB:0]          d2;
	logic signed [17:0]          f1;
	logic signed [17:0]          f2;
	logic signed [37:0]          y;
	logic [31:0]                 ysat;
	logic                        rsp_fire;
	hmtq_pkg::res_t              res_c;

	// A query is taken only when its result is sure to find room in the buffer.
	assign is_query = head_valid && !head.is_wr;
	assign pop      = !busy_q && head_valid &&
		(head.is_wr || (inflight_q < (OW+1)'(hmtq_pkg::OUT_DEPTH)));
	assign wr_en    = pop && head.is_wr;
	assign oor_pop  = pop && is_query && !head.in_range;

	// Issue of one corner read per cycle.
	always_comb begin
		iss   = 1'b0;
		phase = hmtq_pkg::PH_BL;
		src   = head;
		if (busy_q) begin
			iss   = 1'b1;
			phase = phase_q;
			src   = cur_q;
		end else if (pop && is_query && head.in_range) begin
			iss = 1'b1;
		end
		iss_last = iss && (phase == hmtq_pkg::PH_TRI);

		unique case (phase)
			hmtq_pkg::PH_BL: begin
				ca = {1'b0, src.col};
				cb = {1'b0, src.row} + 1'b1;
			end
			hmtq_pkg::PH_TR: begin
				ca = {1'b0, src.col} + 1'b1;
				cb = {1'b0, src.row};
			end
			default: begin
				ca = {1'b0, src.col} + {{(hmtq_pkg::DIM_W-1){1'b0}}, !src.upper};
				cb = {1'b0, src.row} + {{(hmtq_pkg::DIM_W-1){1'b0}}, !src.upper};
			end
		endcase

		// Corners beyond the bounds read as zero.
		czero = (ca > cfg.grid_rows - 1'b1) || (cb > cfg.row_length - 1'b1);
		raddr = ca * cfg.row_length + {{hmtq_pkg::DIM_W{1'b0}}, cb};
		maddr = wr_en ? head.addr : raddr[hmtq_pkg::ADDR_W-1:0];
	end

	// Single-ported store: a write or one read in a cycle.
	always_ff @(posedge clk) begin
		if (wr_en) mem[maddr] <= head.value;
		else if (iss) rd_q <= mem[maddr];
	end

	// Sequencer and in-flight count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			phase_q    <= hmtq_pkg::PH_BL;
			inflight_q <= '0;
		end else begin
			if (busy_q) begin
				if (phase_q == hmtq_pkg::PH_TRI) busy_q <= 1'b0;
				phase_q <= phase_q + 1'b1;
			end else if (iss) begin
				busy_q  <= 1'b1;
				phase_q <= hmtq_pkg::PH_TR;
			end
			if ((pop && is_query) && !rsp_fire) inflight_q <= inflight_q + 1'b1;
			else if (!(pop && is_query) && rsp_fire) inflight_q <= inflight_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && iss) cur_q <= head;
	end

	// Read stage bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
			fin_s1  <= 1'b0;
		end else begin
			rvld_s1 <= iss;
			fin_s1  <= iss_last || oor_pop;
		end
	end

	always_ff @(posedge clk) begin
		rph_s1 <= phase;
		rz_s1  <= czero;
		if (iss_last || oor_pop) meta_s1 <= src;
	end

	assign sample = rz_s1 ? '0 : rd_q;

	// Collect the two shared corners, then form the edge products.
	always_comb begin
		if (meta_s1.upper) begin
			d1 = $signed({1'b0, tr_q}) - $signed({1'b0, sample});
			d2 = $signed({1'b0, bl_q}) - $signed({1'b0, sample});
			f1 = $signed({2'b0, meta_s1.fx});
			f2 = $signed({2'b0, meta_s1.fz});
		end else begin
			d1 = $signed({1'b0, bl_q}) - $signed({1'b0, sample});
			d2 = $signed({1'b0, tr_q}) - $signed({1'b0, sample});
			f1 = $signed({1'b0, 17'h10000 - {1'b0, meta_s1.fx}});
			f2 = $signed({1'b0, 17'h10000 - {1'b0, meta_s1.fz}});
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1 && rph_s1 == hmtq_pkg::PH_BL) bl_q <= sample;
		if (rvld_s1 && rph_s1 == hmtq_pkg::PH_TR) tr_q <= sample;
		ir_s2   <= meta_s1.in_range;
		base_s2 <= sample;
		p1_s2   <= d1 * f1;
		p2_s2   <= d2 * f2;
		ir_s3   <= ir_s2;
		h_s3    <= $signed({5'b0, base_s2, 16'b0}) + (HB+21)'(p1_s2) + (HB+21)'(p2_s2);
		ir_s4   <= ir_s3;
		m_s4    <= $signed(cfg.height_scale) * h_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s2 <= fin_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Scale to Q16.16, add the offset and saturate.
	always_comb begin
		y = 38'(m_s4 >>> 16) + 38'($signed(cfg.height_offset));
		if (y > 38'sd2147483647) ysat = 32'h7FFF_FFFF;
		else if (y < -38'sd2147483648) ysat = 32'h8000_0000;
		else ysat = y[31:0];
		res_c.height   = ir_s4 ? ysat : 32'd0;
		res_c.in_range = ir_s4;
	end

	// Result buffer towards the output channel.
	assign rsp_fire     = rsp.valid && rsp.ready;
	assign rsp.valid    = (ocnt_q != '0);
	assign rsp.height   = ob_q[orp_q].height;
	assign rsp.in_range = ob_q[orp_q].in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (v_s4) owp_q <= owp_q + 1'b1;
			if (rsp_fire) orp_q <= orp_q + 1'b1;
			if (v_s4 && !rsp_fire) ocnt_q <= ocnt_q + 1'b1;
			else if (!v_s4 && rsp_fire) ocnt_q <= ocnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4) ob_q[owp_q] <= res_c;
	end
endmodule
`default_nettype wire

FILE: hdl/heightmap_triangle_height_query_unit.sv
// Top level of the heightmap triangle height query unit.
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, first_index, second_index, entry_value,
//                               query_x, query_z
//  rsp      out  valid/ready    height, in_range (one per query, none per write)
//  cfg      in   cfg_wr_en      cfg_index, cfg_data
//
// A write request uses the height store port once; an in-range query reads its
// three corners one after another on the single store port, and no other request
// is taken from the queue until its last corner read is issued.
// Reset clears control state and loads the register defaults; the store is
// undefined until written. A stalled result channel fills a four-entry buffer
// and the command queue before requests are held off.
`timescale 1ns / 1ps
`default_nettype none
module heightmap_triangle_height_query_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	hmtq_in_if.sink          req,
	hmtq_out_if.source       rsp,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	hmtq_pkg::cfg_t cfg_q;
	hmtq_pkg::cmd_t push_data;
	hmtq_pkg::cmd_t head;
	logic           push;
	logic           q_full;
	logic           pop;
	logic           head_valid;
	logic [hmtq_pkg::DIM_W-1:0] dim_c;

	// Dimensions clamp to the legal range when written.
	always_comb begin
		if (cfg_data[7:0] < 8'd2) dim_c = hmtq_pkg::DIM_W'(2);
		else if (cfg_data[7:0] > 8'(hmtq_pkg::GRID_SIDE))
			dim_c = hmtq_pkg::DIM_W'(hmtq_pkg::GRID_SIDE);
		else dim_c = cfg_data[hmtq_pkg::DIM_W-1:0];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows     <= hmtq_pkg::DIM_W'(hmtq_pkg::GRID_SIDE);
			cfg_q.row_length    <= hmtq_pkg::DIM_W'(hmtq_pkg::GRID_SIDE);
			cfg_q.spacing_recip <= 32'd65536;
			cfg_q.height_scale  <= 24'd65536;
			cfg_q.height_offset <= 32'd0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				hmtq_pkg::REG_GRID_ROWS:     cfg_q.grid_rows     <= dim_c;
				hmtq_pkg::REG_ROW_LENGTH:    cfg_q.row_length    <= dim_c;
				hmtq_pkg::REG_SPACING_RECIP: cfg_q.spacing_recip <= cfg_data;
				hmtq_pkg::REG_HEIGHT_SCALE:  cfg_q.height_scale  <= cfg_data[23:0];
				hmtq_pkg::REG_HEIGHT_OFFSET: cfg_q.height_offset <= cfg_data;
				default: ;
			endcase
		end
	end

	hmtq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req       (req),
		.push      (push),
		.push_data (push_data),
		.q_full    (q_full)
	);

	hmtq_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	hmtq_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.rsp        (rsp)
	);
endmodule
`default_nettype wire
